// File: rtl/pfps_pkg.sv
// shared types and constants for the page framebuffer with pixel scroll
// no dependencies
`default_nettype none

package pfps_pkg;

    // geometry defaults
    localparam int COLUMNS_DEF = 96;
    localparam int PAGES_DEF   = 5;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 9;
    localparam int DATA_W  = 8;
    localparam int SHIFT_W = 6;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SCROLL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CLEAR  = 3'b010,
        ST_SCROLL = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: rtl/page_framebuffer_pixel_scroll_top.sv
// page framebuffer with byte read/write and whole-buffer vertical scroll
// depends on pfps_pkg for field widths, operation codes and state type
//
// usage:
//   input channel i_valid/o_ready carries one request: write byte, read byte
//   or scroll up by i_shift_amount pixels. the store is one memory of COLUMNS
//   rows, each row one column of PAGES bytes with page 0 in the low byte.
//   output channel o_valid/i_ready carries o_read_data, produced by reads only.
//   latency: a read result shows on o_valid the cycle after the request is
//   accepted; reads and writes are taken one per cycle while results drain.
//   a scroll walks the memory one column per cycle through its single read
//   and write port, so it blocks intake until the walk has passed every column.
//   reset: the store is cleared by a pass over all COLUMNS rows,
//   one row per cycle, during which o_ready stays low.
//   stall: a pending read result holds while i_ready is low; a new request
//   is taken only if that result leaves in the same cycle.
`default_nettype none

module page_framebuffer_pixel_scroll_top #(
    parameter int COLUMNS = pfps_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfps_pkg::PAGES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [pfps_pkg::OP_W-1:0]    i_operation,
    input  wire logic [pfps_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [pfps_pkg::DATA_W-1:0]  i_write_data,
    input  wire logic [pfps_pkg::SHIFT_W-1:0] i_shift_amount,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [pfps_pkg::DATA_W-1:0]       o_read_data
);

    localparam int DW       = pfps_pkg::DATA_W;
    localparam int ROW_W    = PAGES * DW;
    localparam int DEPTH    = PAGES * COLUMNS;
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CNT_W    = $clog2(COLUMNS + 1);
    localparam int PG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int EXT_A    = $clog2(DEPTH) + 1;
    localparam int EXT_W    = (EXT_A > pfps_pkg::ADDR_W) ? EXT_A : pfps_pkg::ADDR_W + 1;
    localparam int SH_EXT_W = pfps_pkg::SHIFT_W + 1;

    // frame memory: one row per column, one byte lane per page
    logic [ROW_W-1:0] mem [COLUMNS];

    pfps_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [pfps_pkg::SHIFT_W-1:0] r_shift;
    logic [ROW_W-1:0] r_mem_q;
    logic             r_rd_pend;
    logic             r_rd_oor;
    logic [PG_W-1:0]  r_rd_page;
    logic             r_wb_valid;
    logic [COL_W-1:0] r_wb_col;

    logic             accept;
    pfps_pkg::t_op    op;
    logic [EXT_W-1:0] addr_ext;
    logic [EXT_W-1:0] page_base;
    logic [EXT_W-1:0] col_full;
    logic [PG_W-1:0]  dec_page;
    logic [COL_W-1:0] dec_col;
    logic             in_range;
    logic             scroll_issue;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_row;
    logic [PAGES-1:0] wr_mask;
    logic [ROW_W-1:0] scroll_row;

    // intake handshake
    assign o_ready = (r_state == pfps_pkg::ST_IDLE) && (!r_rd_pend || i_ready);
    assign accept  = i_valid && o_ready;
    assign op      = pfps_pkg::t_op'(i_operation);

    // split address into page and column by comparing against page bases
    assign addr_ext = EXT_W'(i_address);
    assign in_range = addr_ext < EXT_W'(DEPTH);

    always_comb begin
        dec_page  = '0;
        page_base = '0;
        for (int p = 1; p < PAGES; p++) begin
            if (addr_ext >= EXT_W'(p * COLUMNS)) begin
                dec_page  = PG_W'(p);
                page_base = EXT_W'(p * COLUMNS);
            end
        end
    end

    assign col_full = addr_ext - page_base;
    assign dec_col  = col_full[COL_W-1:0];

    // scroll walk issues one column read per cycle
    assign scroll_issue = (r_state == pfps_pkg::ST_SCROLL) && (r_cnt != CNT_W'(COLUMNS));

    // shifted column for write-back, saturating clears the column
    always_comb begin
        if ({1'b0, r_shift} >= SH_EXT_W'(ROW_W)) begin
            scroll_row = '0;
        end else begin
            scroll_row = r_mem_q >> r_shift;
        end
    end

    // memory read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = dec_col;
        if (scroll_issue) begin
            rd_en   = 1'b1;
            rd_addr = r_cnt[COL_W-1:0];
        end else if (accept && (op == pfps_pkg::OP_READ) && in_range) begin
            rd_en = 1'b1;
        end
    end

    // memory write port: clear pass, scroll write-back or byte write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = dec_col;
        wr_row  = {PAGES{i_write_data}};
        wr_mask = '0;
        priority if (r_state == pfps_pkg::ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[COL_W-1:0];
            wr_row  = '0;
            wr_mask = '1;
        end else if (r_wb_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_wb_col;
            wr_row  = scroll_row;
            wr_mask = '1;
        end else if (accept && (op == pfps_pkg::OP_WRITE) && in_range) begin
            wr_en   = 1'b1;
            wr_mask = PAGES'(1) << dec_page;
        end
    end

    // memory array with byte lanes
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int p = 0; p < PAGES; p++) begin
                if (wr_mask[p]) begin
                    mem[wr_addr][p*DW +: DW] <= wr_row[p*DW +: DW];
                end
            end
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            pfps_pkg::ST_CLEAR: begin
                if (r_cnt == CNT_W'(COLUMNS - 1)) begin
                    n_state = pfps_pkg::ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            pfps_pkg::ST_SCROLL: begin
                if (scroll_issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = pfps_pkg::ST_IDLE;
                    n_cnt   = '0;
                end
            end
            pfps_pkg::ST_IDLE: begin
                if (accept && (op == pfps_pkg::OP_SCROLL)) begin
                    n_state = pfps_pkg::ST_SCROLL;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = pfps_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pfps_pkg::ST_CLEAR;
            r_cnt      <= '0;
            r_rd_pend  <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_wb_valid <= scroll_issue;
            if (accept && (op == pfps_pkg::OP_READ)) begin
                r_rd_pend <= 1'b1;
            end else if (i_ready) begin
                r_rd_pend <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wb_col <= r_cnt[COL_W-1:0];
        if (accept && (op == pfps_pkg::OP_SCROLL)) begin
            r_shift <= i_shift_amount;
        end
        if (accept && (op == pfps_pkg::OP_READ)) begin
            r_rd_oor  <= !in_range;
            r_rd_page <= dec_page;
        end
    end

    // result lane select
    assign o_valid     = r_rd_pend;
    assign o_read_data = r_rd_oor ? '0 : r_mem_q[r_rd_page*DW +: DW];

`ifndef ASSERT_OFF
    // a pending read result never overlaps a clear or scroll walk
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pfps_pkg::ST_IDLE) |-> !r_rd_pend)
        else $error("read result pending outside idle");

    // scroll write-back only happens inside the scroll walk
    a_wb_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (r_state == pfps_pkg::ST_SCROLL))
        else $error("write-back outside scroll");

    // column counter stays below COLUMNS during clear and at most COLUMNS during scroll
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == pfps_pkg::ST_CLEAR) |-> (r_cnt < CNT_W'(COLUMNS))) and
        ((r_state == pfps_pkg::ST_SCROLL) |-> (r_cnt <= CNT_W'(COLUMNS))))
        else $error("column counter out of range");

    // an accepted read request yields a result next cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == pfps_pkg::OP_READ)) |=> o_valid)
        else $error("read request without result");
`endif

endmodule

`default_nettype wire

// File: verif/pfps_checker.sv
// checker for the page framebuffer: watches both channels, predicts read bytes
// depends on pfps_pkg for field widths and operation codes
`timescale 1ns / 100ps

module pfps_checker
    import pfps_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_ready,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic [DATA_W-1:0]  i_write_data,
    input  wire logic [SHIFT_W-1:0] i_shift_amount,
    input  wire logic               i_rsp_valid,
    input  wire logic               i_rsp_ready,
    input  wire logic [DATA_W-1:0]  i_read_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int DEPTH    = COLUMNS * PAGES;
    localparam int COL_BITS = PAGES * 8;

    // shadow copy of the frame and the bytes that reads still owe
    logic [DATA_W-1:0] frame_bytes [DEPTH];
    logic [DATA_W-1:0] owed_read_bytes [$];
    logic [DATA_W-1:0] owed_byte;
    int                fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // scroll every column up, zero fill from the bottom, saturate at full height
    task automatic scroll_frame(input logic [SHIFT_W-1:0] amount);
        logic [COL_BITS-1:0] column_word;
        for (int col = 0; col < COLUMNS; col++) begin
            for (int pg = 0; pg < PAGES; pg++) begin
                column_word[pg*8 +: 8] = frame_bytes[pg*COLUMNS + col];
            end
            if (int'(amount) >= COL_BITS) begin
                column_word = '0;
            end else begin
                column_word = column_word >> amount;
            end
            for (int pg = 0; pg < PAGES; pg++) begin
                frame_bytes[pg*COLUMNS + col] = column_word[pg*8 +: 8];
            end
        end
    endtask

    // compare results first, then apply the accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                frame_bytes[i] = '0;
            end
            owed_read_bytes.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_read_bytes.size() == 0) begin
                    $error("read_data: no read outstanding, actual %0h", i_read_data);
                    fail_count++;
                end else begin
                    owed_byte = owed_read_bytes.pop_front();
                    if (i_read_data !== owed_byte) begin
                        $error("read_data mismatch: expected %0h, actual %0h",
                               owed_byte, i_read_data);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                case (t_op'(i_operation))
                    OP_WRITE: begin
                        if (int'(i_address) < DEPTH) begin
                            frame_bytes[i_address] = i_write_data;
                        end
                    end
                    OP_READ: begin
                        owed_read_bytes.push_back(int'(i_address) < DEPTH ?
                                                  frame_bytes[i_address] : '0);
                    end
                    OP_SCROLL: begin
                        scroll_frame(i_shift_amount);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= owed_read_bytes.size();
    end

endmodule

// File: verif/tb_page_framebuffer_pixel_scroll_top.sv
// testbench top for the page framebuffer: clock, reset, request and result drivers
// depends on pfps_pkg, page_framebuffer_pixel_scroll_top and pfps_checker
`timescale 1ns / 100ps

module tb_page_framebuffer_pixel_scroll_top;
    import pfps_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int PAGES       = PAGES_DEF;
    localparam int DEPTH       = COLUMNS * PAGES;
    localparam int NUM_RANDOM  = 1650;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [OP_W-1:0]    i_operation    = '0;
    logic [ADDR_W-1:0]  i_address      = '0;
    logic [DATA_W-1:0]  i_write_data   = '0;
    logic [SHIFT_W-1:0] i_shift_amount = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [DATA_W-1:0]  o_read_data;

    int fail_count;
    int pending_reads;
    int cycle_count = 0;
    int requests_sent = 0;
    bit calm = 1'b0;
    bit hold_done = 1'b0;

    always #1 i_clk = ~i_clk;

    page_framebuffer_pixel_scroll_top #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_shift_amount (i_shift_amount),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_data    (o_read_data)
    );

    pfps_checker #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_shift_amount (i_shift_amount),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_read_data    (o_read_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_reads)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off once traffic is flowing
    always @(posedge i_clk) begin : result_sink
        int hold_left;
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && requests_sent >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // offer one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_request(input t_op op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data,
                                input logic [SHIFT_W-1:0] shift);
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_address      <= addr;
        i_write_data   <= data;
        i_shift_amount <= shift;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
    endtask

    initial begin : stimulus
        int             sent;
        int             pick;
        t_op            op;
        logic [ADDR_W-1:0]  addr;
        logic [SHIFT_W-1:0] shift;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners of the store, dead addresses, unused op, scroll edges
        send_request(OP_WRITE, 9'd0, 8'hFF, 6'd0);
        send_request(OP_WRITE, 9'd479, 8'h81, 6'd63);
        send_request(OP_WRITE, 9'd95, 8'h01, 6'd0);
        send_request(OP_WRITE, 9'd96, 8'h80, 6'd0);
        send_request(OP_WRITE, 9'd480, 8'h55, 6'd0);
        send_request(OP_WRITE, 9'd511, 8'hAA, 6'd0);
        send_request(OP_READ, 9'd0, 8'h00, 6'd0);
        send_request(OP_READ, 9'd479, 8'h00, 6'd0);
        send_request(OP_READ, 9'd480, 8'hFF, 6'd0);
        send_request(OP_READ, 9'd511, 8'h00, 6'd63);
        send_request(OP_NONE, 9'd0, 8'hFF, 6'd63);
        send_request(OP_SCROLL, 9'd0, 8'h00, 6'd0);
        send_request(OP_READ, 9'd96, 8'h00, 6'd0);
        send_request(OP_SCROLL, 9'd0, 8'h00, 6'd1);
        send_request(OP_READ, 9'd0, 8'h00, 6'd0);
        send_request(OP_READ, 9'd96, 8'h00, 6'd0);
        send_request(OP_SCROLL, 9'd0, 8'h00, 6'd8);
        send_request(OP_READ, 9'd0, 8'h00, 6'd0);
        send_request(OP_WRITE, 9'd389, 8'hFF, 6'd0);
        send_request(OP_SCROLL, 9'd0, 8'h00, 6'd39);
        send_request(OP_READ, 9'd5, 8'h00, 6'd0);
        send_request(OP_WRITE, 9'd200, 8'h5A, 6'd0);
        send_request(OP_SCROLL, 9'd0, 8'h00, 6'd40);
        send_request(OP_READ, 9'd200, 8'h00, 6'd0);
        send_request(OP_WRITE, 9'd300, 8'hC3, 6'd0);
        send_request(OP_SCROLL, 9'd0, 8'h00, 6'd63);
        send_request(OP_READ, 9'd300, 8'h00, 6'd0);

        // random: mostly reads and writes, partly on a dense patch, mostly shallow scrolls between
        sent = 0;
        while (sent < NUM_RANDOM) begin
            calm = (sent >= 800 && sent < 1100);
            pick = $urandom_range(99);
            if (pick < 46) begin
                op = OP_WRITE;
            end else if (pick < 88) begin
                op = OP_READ;
            end else if (pick < 95) begin
                op = OP_SCROLL;
            end else begin
                op = OP_NONE;
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                addr = ADDR_W'($urandom_range(511, DEPTH));
            end else if (pick < 45) begin
                addr = ADDR_W'($urandom_range(PAGES-1) * COLUMNS + $urandom_range(7));
            end else begin
                addr = ADDR_W'($urandom_range(DEPTH-1));
            end
            pick = $urandom_range(99);
            if (op != OP_SCROLL) begin
                shift = SHIFT_W'($urandom_range(63));
            end else if (pick < 8) begin
                shift = '0;
            end else if (pick < 15) begin
                shift = SHIFT_W'($urandom_range(63, PAGES*8));
            end else begin
                shift = SHIFT_W'($urandom_range(12, 1));
            end
            send_request(op, addr, DATA_W'($urandom_range(255)), shift);
            sent++;
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // drain outstanding reads, then let any scroll in flight finish
        while (pending_reads != 0) @(posedge i_clk);
        repeat (COLUMNS + 16) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
